// ===== rtl/obs_pkg.sv =====
// Shared constants for the oversampled bit slicer.
package obs_pkg;

  // Width of the samples_per_bit configuration register.
  localparam int CFG_W = 6;

  // Reset value and lower clamp of the window length.
  localparam logic [CFG_W-1:0] SPB_RESET = 6'd8;
  localparam logic [CFG_W-1:0] SPB_MIN   = 6'd2;

  // Register index of samples_per_bit on the configuration port.
  localparam logic ADDR_SPB = 1'b0;

  // Byte width of the stream data buses.
  localparam int TDATA_W = 8;

endpackage

// ===== rtl/oversampled_bit_slicer.sv =====
// Oversampled bit slicer: majority vote over a sample window with transition tracking.
// Sequence: a sample that does not complete a window is only stored. A sample that
// completes a window of n passes through the accept, zero-count, search and consume
// states in that order; the bit is valid the cycle after the consume state.
// Flow: one sample at a time; input waits until the sequencer is idle and the bit is taken.
// Reset (rst, synchronous, active high) empties the window and sets samples_per_bit to 8.
module oversampled_bit_slicer #(
  parameter int MAX_SAMPLES_PER_BIT = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input sample stream.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [obs_pkg::TDATA_W-1:0] s_tdata,   // [0] sample, [7:1] zero
  // Sliced bit stream.
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [obs_pkg::TDATA_W-1:0] m_tdata,   // [0] sliced_bit, [7:1] zero
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // Index width covers the window positions; count width also holds the length itself.
  localparam int IDX_W = $clog2(MAX_SAMPLES_PER_BIT);
  localparam int CNT_W = $clog2(MAX_SAMPLES_PER_BIT + 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a sample
  localparam logic [1:0] ST_COUNT = 2'd1;  // counting zeros, one sample per cycle
  localparam logic [1:0] ST_SRCH  = 2'd2;  // searching outward from the middle
  localparam logic [1:0] ST_FIN   = 2'd3;  // consuming samples and emitting the bit

  logic [1:0]                   state;
  logic [obs_pkg::CFG_W-1:0]    samples_per_bit;
  logic [MAX_SAMPLES_PER_BIT-1:0] window;
  logic [CNT_W-1:0]             fill;
  logic [CNT_W-1:0]             idx;
  logic [CNT_W-1:0]             zeros;
  logic [CNT_W-1:0]             consume;

  logic [CNT_W-1:0]             n_len;
  logic [CNT_W-1:0]             mid;
  logic [CNT_W-1:0]             fill_next;
  logic [CNT_W:0]               fwd_pos;
  logic [CNT_W-1:0]             bwd_pos;
  logic                         fwd_ok;
  logic                         bwd_ok;
  logic                         target;
  logic                         fwd_hit;
  logic                         bwd_hit;
  logic [CNT_W-1:0]             consume_eff;
  logic                         s_fire;
  logic                         cfg_write;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied high.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == obs_pkg::ADDR_SPB);
  assign prdata    = (paddr == obs_pkg::ADDR_SPB) ?
                     {{(32 - obs_pkg::CFG_W){1'b0}}, samples_per_bit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_bit <= obs_pkg::SPB_RESET;
    end else if (cfg_write) begin
      samples_per_bit <= pwdata[obs_pkg::CFG_W-1:0];
    end
  end

  // The window length is clamped to the range the storage supports.
  always_comb begin
    if (samples_per_bit < obs_pkg::SPB_MIN) begin
      n_len = CNT_W'(2);
    end else if (32'(samples_per_bit) > 32'(MAX_SAMPLES_PER_BIT)) begin
      n_len = CNT_W'(MAX_SAMPLES_PER_BIT);
    end else begin
      n_len = CNT_W'(samples_per_bit);
    end
  end

  assign mid = n_len >> 1;

  // ---------------------------------------------------------------------------
  // Handshake. A new sample is taken only while the sequencer is idle and the
  // previous result has been handed off.
  // ---------------------------------------------------------------------------
  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign s_fire   = s_tvalid && s_tready;

  // When the store is already full the incoming sample is dropped.
  assign fill_next = (fill < CNT_W'(MAX_SAMPLES_PER_BIT)) ? fill + CNT_W'(1) : fill;

  // ---------------------------------------------------------------------------
  // Transition search. Step idx checks the forward position mid+idx (distance idx)
  // before the backward position mid-1-idx (distance idx+1). This order finds the
  // nearest transition and lets the backward hit win a tie in distance, because a
  // forward hit at the same distance would only be checked on the next step.
  // ---------------------------------------------------------------------------
  assign target  = ~window[mid[IDX_W-1:0]];
  assign fwd_pos = {1'b0, mid} + {1'b0, idx};
  assign fwd_ok  = fwd_pos < {1'b0, n_len};
  assign bwd_ok  = idx < mid;
  assign bwd_pos = mid - idx - CNT_W'(1);
  assign fwd_hit = fwd_ok && (window[fwd_pos[IDX_W-1:0]] == target);
  assign bwd_hit = bwd_ok && (window[bwd_pos[IDX_W-1:0]] == target);

  // A transition found at the very first position consumes the whole window instead.
  assign consume_eff = (consume == '0) ? n_len : consume;

  // ---------------------------------------------------------------------------
  // Sequencer and control state.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            fill <= fill_next;
            if (fill_next >= n_len) begin
              state <= ST_COUNT;
            end
          end
        end
        ST_COUNT: begin
          if (idx == n_len - CNT_W'(1)) begin
            state <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (fwd_hit || bwd_hit || (!fwd_ok && !bwd_ok)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          fill  <= fill - consume_eff;
          state <= ST_IDLE;
          // A short consume means the bit was already covered; nothing is emitted.
          if (consume_eff > mid) begin
            m_tvalid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers: sample store, step counter, zero count, consume count and
  // the output bit. The store's entries above the fill level hold stale data and
  // are never read.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        idx   <= '0;
        zeros <= '0;
        if (s_fire && (fill < CNT_W'(MAX_SAMPLES_PER_BIT))) begin
          window[fill[IDX_W-1:0]] <= s_tdata[0];
        end
      end
      ST_COUNT: begin
        if (!window[idx[IDX_W-1:0]]) begin
          zeros <= zeros + CNT_W'(1);
        end
        idx <= (idx == n_len - CNT_W'(1)) ? '0 : idx + CNT_W'(1);
      end
      ST_SRCH: begin
        idx <= idx + CNT_W'(1);
        priority if (fwd_hit) begin
          consume <= fwd_pos[CNT_W-1:0];
        end else if (bwd_hit) begin
          consume <= bwd_pos;
        end else begin
          consume <= n_len;
        end
      end
      ST_FIN: begin
        // The kept samples move down to the bottom of the store.
        window <= window >> consume_eff;
        if (consume_eff > mid) begin
          m_tdata <= {{(obs_pkg::TDATA_W - 1){1'b0}}, !(zeros > mid)};
        end
      end
      default: begin
        idx <= '0;
      end
    endcase
  end

endmodule

// ===== test/tb_oversampled_bit_slicer.sv =====
// Self-checking testbench of the oversampled bit slicer: stream stimulus and result prediction.
`timescale 1ns / 100ps

module tb_oversampled_bit_slicer;

  localparam int MAX_SAMPLES = 32;
  // Settling time after a drain, long enough to cover any search still running.
  localparam int SETTLE = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [obs_pkg::TDATA_W-1:0] s_tdata = '0;   // [0] sample, [7:1] zero
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [obs_pkg::TDATA_W-1:0] m_tdata;        // [0] sliced_bit, [7:1] zero

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic paddr = obs_pkg::ADDR_SPB;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  oversampled_bit_slicer #(
    .MAX_SAMPLES_PER_BIT(MAX_SAMPLES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Samples waiting to be driven, and sliced bits that the block still owes us.
  bit sample_q[$];
  bit sliced_q[$];
  int issued_total = 0;
  int accepted_total = 0;
  int fail_count = 0;
  int cycles = 0;

  // When set, neither side inserts wait cycles, so back-to-back transactions occur.
  bit steady = 1'b0;

  // Our own copy of the slicer state: the sample store, its fill level and the register.
  bit win [MAX_SAMPLES];
  int fill = 0;
  logic [obs_pkg::CFG_W-1:0] spb_reg = obs_pkg::SPB_RESET;

  int spb_plan[$] = '{32, 2, 0, 63, 33, 1, 5, 13, 24, 3};

  // Register values outside 2..MAX_SAMPLES are clamped to the nearest legal window length.
  function automatic int win_len(logic [obs_pkg::CFG_W-1:0] spb);
    int n;
    n = int'(spb);
    if (n < int'(obs_pkg::SPB_MIN)) n = int'(obs_pkg::SPB_MIN);
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    return n;
  endfunction

  function automatic int pause_draw();
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  // Append one sample and, once a full window is held, vote on it and realign to the
  // transition nearest the middle of the window.
  function automatic void slice_sample(bit s);
    int n, m, zeros, consume, f, b, i;
    bit have_f, have_b, target, vote;
    n = win_len(spb_reg);
    if (fill < MAX_SAMPLES) begin
      win[fill] = s;
      fill++;
    end
    if (fill < n) return;

    zeros = 0;
    for (i = 0; i < n; i++) begin
      if (!win[i]) zeros++;
    end
    // A tie in the vote decides for one.
    vote = (zeros > n / 2) ? 1'b0 : 1'b1;

    m = n / 2;
    target = !win[m];
    have_f = 1'b0;
    have_b = 1'b0;
    f = 0;
    b = 0;
    for (i = m; i < n; i++) begin
      if (!have_f && win[i] == target) begin
        f = i;
        have_f = 1'b1;
      end
    end
    for (i = m; i > 0; i--) begin
      if (!have_b && win[i-1] == target) begin
        b = i - 1;
        have_b = 1'b1;
      end
    end

    // The backward hit wins a tie in distance.
    if (!have_f && !have_b) consume = n;
    else if (have_f && (!have_b || (f - m) < (m - b))) consume = f;
    else consume = b;
    // A transition at the very first sample means the window was already aligned.
    if (consume == 0) consume = n;

    for (i = 0; i < fill - consume; i++) win[i] = win[i + consume];
    fill -= consume;

    // A short consume only realigns the phase and yields no bit.
    if (consume > n / 2) sliced_q.push_back(vote);
  endfunction

  function automatic void push_sample(bit s);
    sample_q.push_back(s);
    issued_total++;
  endfunction

  // Mostly clean oversampled bits whose run lengths jitter by one sample around the window,
  // with sparse flipped samples, mixed with bursts of pure noise.
  function automatic void queue_stream(int n, int count);
    int run, k;
    bit level;
    while (count > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        run = $urandom_range(1, 2 * n);
        for (k = 0; k < run && count > 0; k++) begin
          push_sample($urandom_range(0, 1) == 1);
          count--;
        end
      end else begin
        level = ($urandom_range(0, 1) == 1);
        run = n + int'($urandom_range(0, 2)) - 1;
        if (run < 1) run = 1;
        for (k = 0; k < run && count > 0; k++) begin
          push_sample(level ^ ($urandom_range(0, 15) == 0));
          count--;
        end
      end
    end
  endfunction

  // Register write with setup and access phases; the predictor takes the new value once the write is done.
  task automatic write_spb(logic [obs_pkg::CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= obs_pkg::ADDR_SPB;
    // Upper data bits are random and must not reach the register.
    pwdata <= ($urandom() & 32'hFFFF_FFC0) | 32'(value);
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    spb_reg = value;
  endtask

  // Wait until every queued sample is taken and every predicted bit has arrived, then give
  // a search that produces no bit time to finish before anything else happens.
  task automatic drain();
    do @(negedge clk); while (accepted_total != issued_total || sliced_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Transaction flags, registered at the rising edge so that the falling-edge drivers see
  // a stable view of what was accepted.
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  // Sample driver: holds an offered sample until it is taken, then pauses before the next.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_fire) begin
      s_tvalid <= 1'b1;
    end else begin
      if (in_fire) in_gap = pause_draw();
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {{(obs_pkg::TDATA_W-1){1'b0}}, sample_q.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: stalls for a random number of cycles after each accepted bit.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_fire) out_gap = pause_draw();
      if (out_gap > 0) begin
        out_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: feeds accepted samples to the predictor and checks each sliced bit in order.
  always @(posedge clk) begin
    bit want;
    in_fire <= !rst && s_tvalid && s_tready;
    out_fire <= !rst && m_tvalid && m_tready;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        slice_sample(s_tdata[0]);
        accepted_total++;
      end
      if (m_tvalid && m_tready) begin
        if (sliced_q.size() == 0) begin
          $error("sliced_bit: no result expected, got %0d", m_tdata[0]);
          fail_count++;
        end else begin
          want = sliced_q.pop_front();
          if (m_tdata[0] !== want) begin
            $error("sliced_bit: expected %0d, got %0d", want, m_tdata[0]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int p, k;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed part at the reset window of eight: a window of all zeros and one of all
    // ones (no transition, whole window consumed), then a lone one ahead of seven zeros,
    // where the only transition sits at the first sample and the whole window goes again.
    steady = 1'b1;
    for (k = 0; k < 8; k++) push_sample(1'b0);
    for (k = 0; k < 8; k++) push_sample(1'b1);
    push_sample(1'b1);
    for (k = 0; k < 7; k++) push_sample(1'b0);
    drain();

    // Random phases. The longest window comes first, so the following change to the
    // shortest one can leave more samples held than the new window length.
    spb_plan.push_back(int'($urandom_range(0, 63)));
    spb_plan.push_back(int'($urandom_range(0, 63)));
    for (p = 0; p < spb_plan.size(); p++) begin
      write_spb(spb_plan[p][obs_pkg::CFG_W-1:0]);
      steady = ($urandom_range(0, 3) == 0);
      queue_stream(win_len(spb_plan[p][obs_pkg::CFG_W-1:0]), 75);
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
